// ===== sv/echo_state_reservoir_step_assert.svh =====
// Assertion macros used by the top RTL file of the reservoir step block.
`ifndef ECHO_STATE_RESERVOIR_STEP_ASSERT_SVH
`define ECHO_STATE_RESERVOIR_STEP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ESR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("esr assertion failed");

// Next-cycle implication, checked outside reset.
`define ESR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("esr assertion failed");

`endif

// ===== sv/esr_pkg.sv =====
`default_nettype none
package esr_pkg;

  localparam int MAX_INPUTS      = 16;
  localparam int MAX_RESERVOIR   = 32;
  localparam int MAX_OUTPUTS     = 8;
  localparam int SIGMOID_ENTRIES = 1024;

  localparam int N_CELLS    = MAX_OUTPUTS + MAX_RESERVOIR;
  localparam int CELL_DEPTH = MAX_INPUTS + MAX_RESERVOIR + MAX_OUTPUTS;
  localparam int CELL_AW    = $clog2(CELL_DEPTH);
  localparam int CELL_IW    = $clog2(N_CELLS);
  localparam int IN_AW      = $clog2(MAX_INPUTS);
  localparam int RES_AW     = $clog2(MAX_RESERVOIR);
  localparam int OUT_AW     = $clog2(MAX_OUTPUTS);
  localparam int SIG_AW     = $clog2(SIGMOID_ENTRIES);

  localparam int VAL_W  = 16;
  localparam int ACT_W  = 13;
  localparam int OP_W   = VAL_W + 1;
  localparam int PROD_W = VAL_W + OP_W;
  localparam int ACC_W  = PROD_W + 6;
  localparam int FRAC_W = 12;

  typedef enum logic [1:0] {
    SEG_IN,
    SEG_RES,
    SEG_FB
  } seg_e;

  // Operand travelling along the cell row.
  typedef struct packed {
    logic                    valid;
    seg_e                    seg;
    logic [RES_AW-1:0]       idx;
    logic signed [OP_W-1:0]  val;
  } op_t;

  typedef struct packed {
    logic [CELL_AW-1:0]      addr;
    logic signed [VAL_W-1:0] data;
  } wr_t;

  typedef logic [ACT_W-1:0] sig_lut_t [SIGMOID_ENTRIES];

  localparam longint ONE_Q30 = 64'sd1 <<< 30;

  // Quotient of two non-negative values by shift and subtract.
  function automatic longint long_div(input longint num, input longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & 64'sd1);
      q = q <<< 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // e^-(m * 8 / E) in Q30 by a power series for e^-y, then four squarings.
  function automatic longint exp_neg_q30(input longint m);
    longint y;
    longint term;
    longint sum;
    int     n;
    y    = (m <<< 31) / (4 * SIGMOID_ENTRIES);
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (n = 1; n <= 14; n++) begin
      term = long_div((term * y) >>> 30, longint'(n));
      if ((n % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    for (n = 0; n < 4; n++) begin
      sum = (sum * sum + (ONE_Q30 >>> 1)) >>> 30;
    end
    return sum;
  endfunction

  function automatic sig_lut_t build_sig_lut();
    sig_lut_t lut;
    longint   twice;
    longint   m;
    longint   e;
    longint   num;
    longint   den;
    longint   tv;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      twice = 2 * longint'(k) + 1;
      m     = (twice < SIGMOID_ENTRIES) ? SIGMOID_ENTRIES - twice : twice - SIGMOID_ENTRIES;
      e     = exp_neg_q30(m);
      num   = (twice < SIGMOID_ENTRIES) ? e : ONE_Q30;
      den   = ONE_Q30 + e;
      tv    = long_div(num * 8192, den);
      lut[k] = ACT_W'((tv + 1) >>> 1);
    end
    return lut;
  endfunction

  localparam sig_lut_t SIG_LUT = build_sig_lut();

endpackage
`default_nettype wire

// ===== sv/esr_cell.sv =====
`default_nettype none
module esr_cell
  import esr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    is_out_i,
  input  logic [4:0]              ic_i,
  input  logic                    clr_i,
  input  logic                    we_i,
  input  wr_t                     wr_i,
  input  op_t                     op_i,
  output op_t                     op_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [VAL_W-1:0]  mem [CELL_DEPTH];
  logic signed [VAL_W-1:0]  rd_q;
  logic [CELL_AW-1:0]       rd_addr;
  op_t                      op_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     use_b;

  // Readout rows follow the live input count; other columns sit at fixed offsets.
  always_comb begin
    unique case (op_i.seg)
      SEG_IN:  rd_addr = CELL_AW'(op_i.idx);
      SEG_RES: rd_addr = is_out_i ? (CELL_AW'(ic_i) + CELL_AW'(op_i.idx))
                                  : (CELL_AW'(MAX_INPUTS) + CELL_AW'(op_i.idx));
      default: rd_addr = CELL_AW'(MAX_INPUTS + MAX_RESERVOIR) + CELL_AW'(op_i.idx);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q.valid <= 1'b0;
      pv_q       <= 1'b0;
    end else begin
      op_q <= op_i;
      pv_q <= use_b;
    end
  end

  // Output nodes take no feedback terms.
  assign use_b = op_q.valid && !(is_out_i && (op_q.seg == SEG_FB));

  always_ff @(posedge clk_i) begin
    prod_q   <= PROD_W'(rd_q) * PROD_W'(op_q.val);
    if (clr_i) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign op_o  = op_q;
  assign acc_o = acc_q;

endmodule
`default_nettype wire

// ===== sv/echo_state_reservoir_step.sv =====
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+---------------------------------------
// in       | sink      | in_valid_i / in_stall_o   | action, matrix_select, row/col, value,
//          |           |                           | last_element
// out      | source    | out_valid_o / out_stall_i | kind, node_index, activation, last
// cfg      | sink      | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// Weight writes, forced activations, clears and non-final elements leave the input
// unstalled. A final element feeds N = input_count + reservoir_count + output_count
// operands, one operand a cycle, into the 40-cell row; the row drains, then the
// shared sigmoid unit reports each output node, then each reservoir node, while
// out_stall_i is low.
// Reset clears counts to their defaults and all activations to zero; weights and
// the input buffer are undefined until written. A stall on the output holds the
// report sequence; the input stays stalled until the final result is loaded.
`default_nettype none
module echo_state_reservoir_step
  import esr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  matrix_select_i,
  input  logic [5:0]  row_index_i,
  input  logic [4:0]  col_index_i,
  input  logic signed [15:0] value_i,
  input  logic        last_element_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [4:0]  node_index_o,
  output logic [12:0] activation_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i
);

  `include "echo_state_reservoir_step_assert.svh"

  typedef enum logic [1:0] {ACT_WRITE, ACT_INPUT, ACT_FORCE, ACT_CLEAR} action_e;
  typedef enum logic [1:0] {MAT_IN, MAT_RES, MAT_FB, MAT_RO} matrix_e;
  typedef enum logic [1:0] {CFG_IC, CFG_RC, CFG_OC, CFG_NONE} cfg_e;
  typedef enum logic [2:0] {ST_IDLE, ST_FEED, ST_DRAIN, ST_SEL, ST_LUT} state_e;

  localparam int DRAIN_CYC = N_CELLS + 4;
  localparam int DR_W      = $clog2(DRAIN_CYC);

  state_e               state_q;
  logic [4:0]           ic_q;
  logic [5:0]           rc_q;
  logic [3:0]           oc_q;
  logic signed [VAL_W-1:0] in_buf_q [MAX_INPUTS];
  logic [ACT_W-1:0]     res_act_q [MAX_RESERVOIR];
  logic [ACT_W-1:0]     out_act_q [MAX_OUTPUTS];

  seg_e                 seg_q;
  logic [RES_AW-1:0]    idx_q;
  logic [DR_W-1:0]      dr_q;
  op_t                  inj_q;
  logic                 rep_kind_q;
  logic [RES_AW-1:0]    rep_idx_q;
  logic signed [VAL_W-1:0] sat_q;

  logic                 out_valid_q;
  logic                 kind_q;
  logic [4:0]           node_q;
  logic [ACT_W-1:0]     act_q;
  logic                 last_q;

  logic                 in_acc;
  logic                 fire;
  logic                 wr_ok;
  logic [CELL_IW-1:0]   wr_cell;
  wr_t                  wr;
  logic [N_CELLS-1:0]   wr_en;
  op_t                  chain [N_CELLS+1];
  logic signed [ACC_W-1:0] acc [N_CELLS];
  logic [5:0]           seg_len;
  logic                 seg_end;
  logic signed [OP_W-1:0] inj_val;
  logic [CELL_IW-1:0]   rep_cell;
  logic signed [ACC_W-FRAC_W-1:0] acc_fl;
  logic signed [VAL_W-1:0] sat_d;
  logic [VAL_W-1:0]     sat_u;
  logic [ACT_W-1:0]     lut_val;
  logic                 rep_last;
  logic                 out_free;
  logic                 lut_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fire       = in_acc && (action_e'(action_i) == ACT_INPUT) && last_element_i;

  // Map a weight write onto the cell that owns its column.
  always_comb begin
    wr_ok   = 1'b0;
    wr_cell = '0;
    wr.addr = '0;
    wr.data = value_i;
    unique case (matrix_e'(matrix_select_i))
      MAT_IN: begin
        wr_ok   = (row_index_i < 6'(MAX_INPUTS)) && ({1'b0, col_index_i} < 6'(MAX_RESERVOIR));
        wr_cell = CELL_IW'(MAX_OUTPUTS) + CELL_IW'(col_index_i);
        wr.addr = CELL_AW'(row_index_i);
      end
      MAT_RES: begin
        wr_ok   = (row_index_i < 6'(MAX_RESERVOIR)) && ({1'b0, col_index_i} < 6'(MAX_RESERVOIR));
        wr_cell = CELL_IW'(MAX_OUTPUTS) + CELL_IW'(col_index_i);
        wr.addr = CELL_AW'(MAX_INPUTS) + CELL_AW'(row_index_i);
      end
      MAT_FB: begin
        wr_ok   = (row_index_i < 6'(MAX_OUTPUTS)) && ({1'b0, col_index_i} < 6'(MAX_RESERVOIR));
        wr_cell = CELL_IW'(MAX_OUTPUTS) + CELL_IW'(col_index_i);
        wr.addr = CELL_AW'(MAX_INPUTS + MAX_RESERVOIR) + CELL_AW'(row_index_i);
      end
      default: begin
        wr_ok   = (row_index_i < 6'(MAX_INPUTS + MAX_RESERVOIR)) &&
                  ({1'b0, col_index_i} < 6'(MAX_OUTPUTS));
        wr_cell = CELL_IW'(col_index_i);
        wr.addr = CELL_AW'(row_index_i);
      end
    endcase
    wr_en = (in_acc && (action_e'(action_i) == ACT_WRITE) && wr_ok)
          ? (N_CELLS'(1) << wr_cell) : '0;
  end

  // Cell row: output nodes first, then reservoir nodes.
  assign chain[0] = inj_q;
  for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
    esr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .is_out_i (1'(c < MAX_OUTPUTS)),
      .ic_i     (ic_q),
      .clr_i    (fire),
      .we_i     (wr_en[c]),
      .wr_i     (wr),
      .op_i     (chain[c]),
      .op_o     (chain[c+1]),
      .acc_o    (acc[c])
    );
  end

  // Configuration: saturate into range (ic/oc from low data bits only); ignore unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= 5'(MAX_INPUTS);
      rc_q <= 6'(MAX_RESERVOIR);
      oc_q <= 4'(MAX_OUTPUTS);
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_IC: ic_q <= (cfg_data_i[4:0] == 5'd0) ? 5'd1 :
                        ((cfg_data_i[4:0] > 5'(MAX_INPUTS)) ? 5'(MAX_INPUTS) : cfg_data_i[4:0]);
        CFG_RC: rc_q <= (cfg_data_i == 6'd0) ? 6'd1 :
                        ((cfg_data_i > 6'(MAX_RESERVOIR)) ? 6'(MAX_RESERVOIR) : cfg_data_i);
        CFG_OC: oc_q <= (cfg_data_i[3:0] == 4'd0) ? 4'd1 :
                        ((cfg_data_i[3:0] > 4'(MAX_OUTPUTS)) ? 4'(MAX_OUTPUTS) : cfg_data_i[3:0]);
        default: ;
      endcase
    end
  end

  // Input buffer.
  always_ff @(posedge clk_i) begin
    if (in_acc && (action_e'(action_i) == ACT_INPUT) && (row_index_i < 6'(MAX_INPUTS))) begin
      in_buf_q[row_index_i[IN_AW-1:0]] <= value_i;
    end
  end

  // Activations: clear, force, and new values as each node is reported.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_RESERVOIR; j++) res_act_q[j] <= '0;
      for (int k = 0; k < MAX_OUTPUTS; k++) out_act_q[k] <= '0;
    end else if (in_acc && (action_e'(action_i) == ACT_CLEAR)) begin
      for (int j = 0; j < MAX_RESERVOIR; j++) res_act_q[j] <= '0;
      for (int k = 0; k < MAX_OUTPUTS; k++) out_act_q[k] <= '0;
    end else if (in_acc && (action_e'(action_i) == ACT_FORCE) &&
                 (row_index_i < 6'(MAX_OUTPUTS))) begin
      out_act_q[row_index_i[OUT_AW-1:0]] <= value_i[15] ? '0 :
        ((value_i > 16'sd4096) ? ACT_W'(4096) : ACT_W'(value_i));
    end else if (lut_load) begin
      if (rep_kind_q) res_act_q[rep_idx_q] <= lut_val;
      else out_act_q[rep_idx_q[OUT_AW-1:0]] <= lut_val;
    end
  end

  // Operand feed: inputs, then old reservoir, then old output activations.
  always_comb begin
    unique case (seg_q)
      SEG_IN:  seg_len = {1'b0, ic_q};
      SEG_RES: seg_len = rc_q;
      default: seg_len = {2'b0, oc_q};
    endcase
    seg_end = (({1'b0, idx_q} + 6'd1) == seg_len);
    unique case (seg_q)
      SEG_IN:  inj_val = OP_W'(in_buf_q[idx_q[IN_AW-1:0]]);
      SEG_RES: inj_val = {4'b0, res_act_q[idx_q]};
      default: inj_val = {4'b0, out_act_q[idx_q[OUT_AW-1:0]]};
    endcase
  end

  // Report path: floor to Q4.12, saturate, then look up the sigmoid.
  always_comb begin
    rep_cell = rep_kind_q ? (CELL_IW'(MAX_OUTPUTS) + CELL_IW'(rep_idx_q)) : CELL_IW'(rep_idx_q);
    acc_fl   = acc[rep_cell][ACC_W-1:FRAC_W];
    if (acc_fl > (ACC_W-FRAC_W)'(32767)) sat_d = 16'sh7fff;
    else if (acc_fl < -(ACC_W-FRAC_W)'(32768)) sat_d = -16'sh8000;
    else sat_d = acc_fl[VAL_W-1:0];
    sat_u    = sat_q ^ 16'h8000;
    lut_val  = SIG_LUT[sat_u[VAL_W-1 -: SIG_AW]];
    rep_last = rep_kind_q && (({1'b0, rep_idx_q} + 6'd1) == rc_q);
    out_free = !out_valid_q || !out_stall_i;
    lut_load = (state_q == ST_LUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_q       <= SEG_IN;
      idx_q       <= '0;
      dr_q        <= '0;
      inj_q.valid <= 1'b0;
      rep_kind_q  <= 1'b0;
      rep_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      inj_q.valid <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (fire) begin
            seg_q   <= SEG_IN;
            idx_q   <= '0;
            state_q <= ST_FEED;
          end
        end
        ST_FEED: begin
          inj_q.valid <= 1'b1;
          inj_q.seg   <= seg_q;
          inj_q.idx   <= idx_q;
          inj_q.val   <= inj_val;
          idx_q       <= seg_end ? '0 : idx_q + 1'b1;
          if (seg_end) begin
            unique case (seg_q)
              SEG_IN:  seg_q <= SEG_RES;
              SEG_RES: seg_q <= SEG_FB;
              default: begin
                dr_q    <= DR_W'(DRAIN_CYC - 1);
                state_q <= ST_DRAIN;
              end
            endcase
          end
        end
        ST_DRAIN: begin
          dr_q <= dr_q - 1'b1;
          if (dr_q == '0) begin
            rep_kind_q <= 1'b0;
            rep_idx_q  <= '0;
            state_q    <= ST_SEL;
          end
        end
        ST_SEL: begin
          sat_q   <= sat_d;
          state_q <= ST_LUT;
        end
        default: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= rep_kind_q;
            node_q      <= 5'(rep_idx_q);
            act_q       <= lut_val;
            last_q      <= rep_last;
            if (rep_last) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_SEL;
              if (!rep_kind_q && (({1'b0, rep_idx_q} + 6'd1) == {2'b0, oc_q})) begin
                rep_kind_q <= 1'b1;
                rep_idx_q  <= '0;
              end else begin
                rep_idx_q <= rep_idx_q + 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign node_index_o = node_q;
  assign activation_o = act_q;
  assign last_o       = last_q;

  `ESR_ASSERT_IMPL(a_act_range, out_valid_o, activation_o <= 13'd4096)
  `ESR_ASSERT_IMPL(a_last_is_res, out_valid_o && last_o, kind_o)
  `ESR_ASSERT_NEXT(a_fire_feeds, fire, state_q == ST_FEED)
  `ESR_ASSERT_NEXT(a_drain_done, (state_q == ST_DRAIN) && (dr_q == '0), state_q == ST_SEL)

endmodule
`default_nettype wire
